FILE: rtl/core/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the degree sine/cosine core
// Fixed-point constants, stage payload types and divider sizing.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Number of series terms, including the leading term (valid range 4 to 16).
  localparam int TERMS = 10;

  // Angle reduction constants, in Q16.16 degrees where a fraction is present.
  localparam logic [24:0] DEG_HALF    = 25'(180 << 16);
  localparam logic [24:0] DEG_QUARTER = 25'(90 << 16);
  localparam logic [8:0]  DEG_FULL_INT = 9'd360;

  // Reciprocal of 360 used to reduce the integer degree count.
  localparam logic [13:0] MOD_RECIP = 14'd11650;
  localparam int          MOD_SHIFT = 22;

  // Degrees to radians, round(pi / 180 * 2^46).
  localparam logic [40:0] RAD_K = 41'd1228166276394;

  // 1.0 in Q2.62 and in Q2.30.
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [32:0] ONE_Q30 = 33'h0_4000_0000;

  // Constant divider sizing: 16-bit digits, divisors up to 930.
  localparam int CH_W        = 16;
  localparam int NCH         = 64 / CH_W;
  localparam int DIV_W       = 10;
  localparam int VAL_W       = DIV_W + CH_W;
  localparam int RC_W        = 27;
  localparam int RECIP_SHIFT = 27;

  // Item leaving the front end: folded angle in Q2.62 radians.
  typedef struct packed {
    logic        func;
    logic        neg;
    logic [63:0] x;
  } dsc_front_t;

  // Item travelling through the series pipeline.
  typedef struct packed {
    logic        func;
    logic        neg;
    logic [63:0] x2;
    logic [63:0] mag;
    logic [63:0] sum;
  } dsc_side_t;

endpackage

FILE: rtl/core/dsc_front.sv
// ----------------------------------------------------------------------------
// dsc_front: angle reduction and radian conversion
// Takes |angle| modulo 360 degrees, folds it into the first quadrant while
// tracking the sign, and scales it to Q2.62 radians over five stages.
// ----------------------------------------------------------------------------
module dsc_front import dsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               func_i,
  input  logic signed [31:0] angle_i,
  output logic               valid_o,
  output dsc_front_t         item_o
);

  logic [31:0] raw;
  logic [31:0] m_c;

  logic        s1_v_q, s1_func_q, s1_neg_q;
  logic [31:0] s1_m_q;
  logic [29:0] s1_prod_q;

  logic        s2_v_q, s2_func_q, s2_neg_q;
  logic [24:0] s2_r_q;
  logic [7:0]  quo_c;
  logic [16:0] rem_c;
  logic [16:0] rem_fix_c;

  logic        s3_v_q, s3_func_q, s3_neg_q;
  logic [22:0] s3_r_q;
  logic [24:0] r1_c;
  logic [24:0] r2_c;
  logic        neg1_c, neg2_c;

  logic        s4_v_q, s4_func_q, s4_neg_q;
  logic [54:0] s4_plo_q;
  logic [31:0] s4_phi_q;

  logic        s5_v_q, s5_func_q, s5_neg_q;
  logic [63:0] s5_x_q;

  // Magnitude of the angle; the most negative value gives 2^31 naturally.
  assign raw = angle_i;
  assign m_c = raw[31] ? (32'd0 - raw) : raw;

  // Integer degrees modulo 360: estimate the quotient, then correct once.
  always_comb begin
    quo_c     = s1_prod_q[29:MOD_SHIFT];
    rem_c     = {1'b0, s1_m_q[31:16]} - 17'(quo_c * DEG_FULL_INT);
    rem_fix_c = (rem_c >= 17'(DEG_FULL_INT)) ? (rem_c - 17'(DEG_FULL_INT)) : rem_c;
  end

  // Fold into the first quadrant.
  always_comb begin
    r1_c   = s2_r_q;
    neg1_c = s2_neg_q;
    if (s2_r_q > DEG_HALF) begin
      r1_c   = s2_r_q - DEG_HALF;
      neg1_c = ~s2_neg_q;
    end
    r2_c   = r1_c;
    neg2_c = neg1_c;
    if (r1_c > DEG_QUARTER) begin
      r2_c = DEG_HALF - r1_c;
      if (s2_func_q) begin
        neg2_c = ~neg1_c;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_func_q <= func_i;
      s1_neg_q  <= ~func_i & raw[31];
      s1_m_q    <= m_c;
      s1_prod_q <= 30'(m_c[31:16] * MOD_RECIP);

      s2_func_q <= s1_func_q;
      s2_neg_q  <= s1_neg_q;
      s2_r_q    <= {rem_fix_c[8:0], s1_m_q[15:0]};

      s3_func_q <= s2_func_q;
      s3_neg_q  <= neg2_c;
      s3_r_q    <= r2_c[22:0];

      s4_func_q <= s3_func_q;
      s4_neg_q  <= s3_neg_q;
      s4_plo_q  <= 55'(s3_r_q * RAD_K[31:0]);
      s4_phi_q  <= 32'(s3_r_q * RAD_K[40:32]);

      s5_func_q <= s4_func_q;
      s5_neg_q  <= s4_neg_q;
      s5_x_q    <= {9'd0, s4_plo_q} + {s4_phi_q, 32'd0};
    end
  end

  assign valid_o     = s5_v_q;
  assign item_o.func = s5_func_q;
  assign item_o.neg  = s5_neg_q;
  assign item_o.x    = s5_x_q;

endmodule

FILE: rtl/core/dsc_mulq62.sv
// ----------------------------------------------------------------------------
// dsc_mulq62: two-stage Q2.62 multiplier
// Forms floor(a * b / 2^62) modulo 2^64 from four 32x32 partial products.
// ----------------------------------------------------------------------------
module dsc_mulq62 import dsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  dsc_side_t   side_i,
  output logic        valid_o,
  output logic [63:0] p_o,
  output dsc_side_t   side_o
);

  logic        s1_v_q, s2_v_q;
  logic [63:0] hh_q, hl_q, lh_q, ll_q;
  dsc_side_t   s1_side_q, s2_side_q;
  logic [63:0] s2_p_q;
  logic [127:0] full_c;

  // Partial products are summed into the full 128-bit product.
  assign full_c = {hh_q, 64'd0} + {32'd0, hl_q, 32'd0} + {32'd0, lh_q, 32'd0}
                + {64'd0, ll_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q      <= a_i[63:32] * b_i[63:32];
      hl_q      <= a_i[63:32] * b_i[31:0];
      lh_q      <= a_i[31:0] * b_i[63:32];
      ll_q      <= a_i[31:0] * b_i[31:0];
      s1_side_q <= side_i;
      s2_p_q    <= full_c[125:62];
      s2_side_q <= s1_side_q;
    end
  end

  assign valid_o = s2_v_q;
  assign p_o     = s2_p_q;
  assign side_o  = s2_side_q;

endmodule

FILE: rtl/core/dsc_divc.sv
// ----------------------------------------------------------------------------
// dsc_divc: pipelined division by a small constant
// Long division in 16-bit digits; each digit takes a reciprocal multiply
// stage and a correction stage. The divisor is chosen per item by func.
// ----------------------------------------------------------------------------
module dsc_divc import dsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [63:0]      num_i,
  input  logic [DIV_W-1:0] div_sin_i,
  input  logic [DIV_W-1:0] div_cos_i,
  input  logic [RC_W-1:0]  rc_sin_i,
  input  logic [RC_W-1:0]  rc_cos_i,
  input  dsc_side_t        side_i,
  output logic             valid_o,
  output logic [63:0]      quo_o,
  output dsc_side_t        side_o
);

  localparam int PROD_W = VAL_W + RC_W;

  // Multiply stage registers, one set per digit.
  logic                  a_v_q    [NCH];
  logic [VAL_W-1:0]      a_val_q  [NCH];
  logic [PROD_W-1:0]     a_prod_q [NCH];
  logic [63:0]           a_num_q  [NCH];
  logic [63:0]           a_quo_q  [NCH];
  logic [DIV_W-1:0]      a_d_q    [NCH];
  logic [RC_W-1:0]       a_rc_q   [NCH];
  dsc_side_t             a_side_q [NCH];

  // Correction stage registers, one set per digit.
  logic                  b_v_q    [NCH];
  logic [DIV_W-1:0]      b_rem_q  [NCH];
  logic [63:0]           b_num_q  [NCH];
  logic [63:0]           b_quo_q  [NCH];
  logic [DIV_W-1:0]      b_d_q    [NCH];
  logic [RC_W-1:0]       b_rc_q   [NCH];
  dsc_side_t             b_side_q [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_digit
    localparam int HI = 63 - c * CH_W;

    logic             in_v;
    logic [DIV_W-1:0] in_rem;
    logic [63:0]      in_num;
    logic [63:0]      in_quo;
    logic [DIV_W-1:0] in_d;
    logic [RC_W-1:0]  in_rc;
    dsc_side_t        in_side;
    logic [VAL_W-1:0] val_c;
    logic [CH_W-1:0]  qe_c;
    logic [VAL_W-1:0] r_c;
    logic [CH_W-1:0]  qfix_c;
    logic [VAL_W-1:0] rfix_c;
    logic [63:0]      quo_c;

    // Digit input: the module input for the first digit, else the previous digit.
    always_comb begin
      if (c == 0) begin
        in_v    = valid_i;
        in_rem  = '0;
        in_num  = num_i;
        in_quo  = '0;
        in_d    = side_i.func ? div_cos_i : div_sin_i;
        in_rc   = side_i.func ? rc_cos_i : rc_sin_i;
        in_side = side_i;
      end else begin
        in_v    = b_v_q[(c == 0) ? 0 : c - 1];
        in_rem  = b_rem_q[(c == 0) ? 0 : c - 1];
        in_num  = b_num_q[(c == 0) ? 0 : c - 1];
        in_quo  = b_quo_q[(c == 0) ? 0 : c - 1];
        in_d    = b_d_q[(c == 0) ? 0 : c - 1];
        in_rc   = b_rc_q[(c == 0) ? 0 : c - 1];
        in_side = b_side_q[(c == 0) ? 0 : c - 1];
      end
    end

    assign val_c = {in_rem, in_num[HI -: CH_W]};

    // Quotient estimate is exact or one low; one compare fixes it.
    always_comb begin
      qe_c   = a_prod_q[c][RECIP_SHIFT +: CH_W];
      r_c    = a_val_q[c] - VAL_W'(qe_c * a_d_q[c]);
      qfix_c = qe_c;
      rfix_c = r_c;
      if (r_c >= VAL_W'(a_d_q[c])) begin
        qfix_c = qe_c + 1'b1;
        rfix_c = r_c - VAL_W'(a_d_q[c]);
      end
      quo_c            = a_quo_q[c];
      quo_c[HI -: CH_W] = qfix_c;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[c] <= 1'b0;
        b_v_q[c] <= 1'b0;
      end else if (en_i) begin
        a_v_q[c] <= in_v;
        b_v_q[c] <= a_v_q[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_val_q[c]  <= val_c;
        a_prod_q[c] <= PROD_W'(val_c * in_rc);
        a_num_q[c]  <= in_num;
        a_quo_q[c]  <= in_quo;
        a_d_q[c]    <= in_d;
        a_rc_q[c]   <= in_rc;
        a_side_q[c] <= in_side;

        b_rem_q[c]  <= rfix_c[DIV_W-1:0];
        b_num_q[c]  <= a_num_q[c];
        b_quo_q[c]  <= quo_c;
        b_d_q[c]    <= a_d_q[c];
        b_rc_q[c]   <= a_rc_q[c];
        b_side_q[c] <= a_side_q[c];
      end
    end
  end

  assign valid_o = b_v_q[NCH-1];
  assign quo_o   = b_quo_q[NCH-1];
  assign side_o  = b_side_q[NCH-1];

endmodule

FILE: rtl/core/degree_sine_cosine_core.sv
// ----------------------------------------------------------------------------
// degree_sine_cosine_core: sine or cosine of a Q16.16 angle in degrees
// Fully pipelined Taylor series evaluation with a two-entry output buffer.
// ----------------------------------------------------------------------------
// The core accepts one item per cycle while stall_o is low and returns one
// Q2.30 result per item, in order. Five front stages reduce and fold the
// angle and scale it to radians, a two-stage multiplier squares it, and
// each further series term uses a two-stage 64x64 multiplier followed by
// an eight-stage constant divider. Three final stages apply the sign,
// rounding and saturation. Stall from the output side freezes the
// pipeline only once the output buffer holds two results; stall_o then
// stays high until the receiver takes one.
// ----------------------------------------------------------------------------
module degree_sine_cosine_core import dsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               func_i,
  input  logic signed [31:0] angle_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] result_o
);

  logic        en;
  logic        sk_v_q, out_v_q;
  logic [31:0] sk_q, out_q;

  logic        fr_v;
  dsc_front_t  fr_item;
  dsc_side_t   sq_side_in, sq_side_out;
  logic        sq_v;
  logic [63:0] sq_p;

  logic        link_v    [TERMS];
  dsc_side_t   link_side [TERMS];

  logic        f1_v_q, f2_v_q, f3_v_q;
  logic        f1_neg_q, f2_neg_q, f3_neg_q;
  logic [63:0] f1_sum_q, f2_mag_q;
  logic [30:0] f3_v_val_q;
  logic [32:0] rnd_c;
  logic [31:0] res_c;
  logic        push;

  // The pipeline advances unless the output buffer is full.
  assign en      = ~sk_v_q;
  assign stall_o = sk_v_q;

  dsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .func_i  (func_i),
    .angle_i (angle_i),
    .valid_o (fr_v),
    .item_o  (fr_item)
  );

  // Square of the angle; the leading term starts the running sum.
  always_comb begin
    sq_side_in.func = fr_item.func;
    sq_side_in.neg  = fr_item.neg;
    sq_side_in.x2   = '0;
    sq_side_in.mag  = fr_item.func ? ONE_Q62 : fr_item.x;
    sq_side_in.sum  = fr_item.func ? ONE_Q62 : fr_item.x;
  end

  dsc_mulq62 u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .a_i     (fr_item.x),
    .b_i     (fr_item.x),
    .side_i  (sq_side_in),
    .valid_o (sq_v),
    .p_o     (sq_p),
    .side_o  (sq_side_out)
  );

  always_comb begin
    link_v[0]       = sq_v;
    link_side[0]    = sq_side_out;
    link_side[0].x2 = sq_p;
  end

  // One multiply and one constant divide for each further term.
  for (genvar k = 1; k < TERMS; k++) begin : g_term
    localparam int NS  = 2 * k + 1;
    localparam int DS  = NS * (NS - 1);
    localparam int DC  = (2 * k) * (2 * k - 1);
    localparam int RSN = (1 << RECIP_SHIFT) / DS;
    localparam int RCS = (1 << RECIP_SHIFT) / DC;

    logic        mv;
    logic [63:0] mp;
    dsc_side_t   mside;
    logic        dv;
    logic [63:0] dq;
    dsc_side_t   dside;

    dsc_mulq62 u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (link_v[k-1]),
      .a_i     (link_side[k-1].mag),
      .b_i     (link_side[k-1].x2),
      .side_i  (link_side[k-1]),
      .valid_o (mv),
      .p_o     (mp),
      .side_o  (mside)
    );

    dsc_divc u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (mv),
      .num_i     (mp),
      .div_sin_i (DIV_W'(DS)),
      .div_cos_i (DIV_W'(DC)),
      .rc_sin_i  (RC_W'(RSN)),
      .rc_cos_i  (RC_W'(RCS)),
      .side_i    (mside),
      .valid_o   (dv),
      .quo_o     (dq),
      .side_o    (dside)
    );

    // Terms alternate in sign, starting with a subtraction.
    always_comb begin
      link_v[k]        = dv;
      link_side[k]     = dside;
      link_side[k].mag = dq;
      link_side[k].sum = (k % 2 == 1) ? (dside.sum - dq) : (dside.sum + dq);
    end
  end

  // Final stages: absolute value, rounding to Q2.30 and saturation.
  assign rnd_c = {1'b0, f2_mag_q[63:32]} + {32'd0, f2_mag_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= link_v[TERMS-1];
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_sum_q   <= link_side[TERMS-1].sum;
      f1_neg_q   <= link_side[TERMS-1].neg;
      f2_mag_q   <= f1_sum_q[63] ? (64'd0 - f1_sum_q) : f1_sum_q;
      f2_neg_q   <= f1_neg_q ^ f1_sum_q[63];
      f3_v_val_q <= (rnd_c > ONE_Q30) ? ONE_Q30[30:0] : rnd_c[30:0];
      f3_neg_q   <= f2_neg_q;
    end
  end

  assign res_c = f3_neg_q ? (32'd0 - {1'b0, f3_v_val_q}) : {1'b0, f3_v_val_q};
  assign push  = en & f3_v_q;

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || !stall_i) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !stall_i) begin
      out_q <= sk_v_q ? sk_q : res_c;
    end else if (push) begin
      sk_q <= res_c;
    end
  end

  assign valid_o  = out_v_q;
  assign result_o = out_q;

endmodule

FILE: rtl/core/dsc_checker.sv
// ----------------------------------------------------------------------------
// dsc_checker: port-level checks of the degree sine/cosine core
// Watches the handshakes and result range; bound to the top level.
// ----------------------------------------------------------------------------
module dsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               stall_o,
  input logic               func_i,
  input logic signed [31:0] angle_i,
  input logic               valid_o,
  input logic               stall_i,
  input logic signed [31:0] result_o
);

  // Results never exceed one in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o >= -32'sd1073741824 && result_o <= 32'sd1073741824))
    else $error("result out of range");

  // A stalled result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_o))
    else $error("stalled result changed");

  // Input stall only rises after the output was held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("input stall without output backpressure");

  // With the buffer full there is always a result on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("stall without pending result");

  // An edge seen in reset leaves no result offered and no stall at the next edge.
  assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o && !stall_o)
    else $error("output active during reset");

endmodule

bind degree_sine_cosine_core dsc_checker u_dsc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (valid_i),
  .stall_o  (stall_o),
  .func_i   (func_i),
  .angle_i  (angle_i),
  .valid_o  (valid_o),
  .stall_i  (stall_i),
  .result_o (result_o)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the degree sine/cosine core
// Drives angles with random gaps, predicts each sine or cosine in fixed point
// and checks every result item in order against that prediction.
// ----------------------------------------------------------------------------

// Predicts results and keeps the items still in flight.
class trig_scoreboard;
  logic signed [31:0] pending_q[$];
  int errors;
  int checked;

  // Returns floor(a * b / 2^62) modulo 2^64.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Works out the Q2.30 sine or cosine of a Q16.16 angle in degrees.
  function automatic logic signed [31:0] predict_trig(logic is_cos, logic [31:0] raw);
    logic [63:0] m, r, x, x2, mag, sum, smag, v, n;
    logic neg, tneg, sneg;
    m = raw[31] ? {32'd0, 32'd0 - raw} : {32'd0, raw};
    if (raw[31] && m == 64'd0) m = 64'd1 << 31;
    neg = !is_cos && raw[31];
    r = m % (64'd360 << 16);
    if (r > (64'd180 << 16)) begin
      r = r - (64'd180 << 16);
      neg = !neg;
    end
    if (r > (64'd90 << 16)) begin
      r = (64'd180 << 16) - r;
      if (is_cos) neg = !neg;
    end
    x = r * 64'd1228166276394;
    x2 = mul_q62(x, x);
    mag = is_cos ? (64'd1 << 62) : x;
    sum = mag;
    tneg = 1'b0;
    n = is_cos ? 64'd2 : 64'd3;
    for (int k = 1; k < dsc_pkg::TERMS; k++) begin
      mag = mul_q62(mag, x2) / (n * (n - 64'd1));
      tneg = !tneg;
      sum = tneg ? sum - mag : sum + mag;
      n = n + 64'd2;
    end
    sneg = sum[63];
    smag = sneg ? 64'd0 - sum : sum;
    if (sneg) neg = !neg;
    v = (smag >> 32) + ((smag >> 31) & 64'd1);
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    v = neg ? 64'd0 - v : v;
    return v[31:0];
  endfunction

  function void note_angle(logic is_cos, logic [31:0] raw);
    pending_q.push_back(predict_trig(is_cos, raw));
  endfunction

  function void check_result(logic signed [31:0] got);
    logic signed [31:0] want;
    checked++;
    if (pending_q.size() == 0) begin
      $error("result %0d arrived with no item pending", got);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      $error("result mismatch: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import dsc_pkg::*;

  localparam int NUM_RANDOM = 530;
  localparam int LATENCY = 5 + 2 + 10 * (TERMS - 1) + 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic func_i = 1'b0;
  logic signed [31:0] angle_i = '0;
  logic stall_i = 1'b1;
  logic stall_o, valid_o;
  logic signed [31:0] result_o;

  trig_scoreboard sb = new();
  int cycle_count = 0;
  int sent = 0;
  bit hold_off = 1'b0;

  degree_sine_cosine_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .func_i(func_i), .angle_i(angle_i), .valid_o(valid_o), .stall_i(stall_i),
    .result_o(result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits until the core takes it. Valid drops only
  // for a gap, so back-to-back items keep it high.
  task automatic send_angle(logic is_cos, logic [31:0] a, int gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    func_i <= is_cos;
    angle_i <= a;
    do @(posedge clk_i); while (stall_o);
    sb.note_angle(is_cos, a);
    sent++;
  endtask

  // Random angles of varied scale, with every bit exercised.
  function automatic logic [31:0] random_angle();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) return $urandom();
    if (p < 7) return 32'($signed($urandom_range(0, 1440 << 16)) - (720 << 16));
    if (p < 9) return 32'($urandom_range(0, 8) * (45 << 16)) + 32'($urandom_range(0, 3)) - 2;
    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Timeout.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender runs.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
        stall_i <= 1'b0;
      end else begin
        g = $urandom_range(0, 99);
        stall_i <= (sent > 200 && sent < 260) ? 1'b0 : (g < 25);
      end
    end
  end

  // Result items are sampled at the edge they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_result(result_o);
  end

  // Stimulus: directed extremes and quadrant edges, then random items.
  initial begin
    logic [31:0] directed[12];
    int wait_cycles;
    directed = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1,
                 32'(90 << 16), 32'(180 << 16), 32'(270 << 16), 32'(360 << 16),
                 32'(-90 << 16), 32'(45 << 16), 32'(90 << 16) + 32'd1};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_angle(1'b0, directed[i], 0);
      send_angle(1'b1, directed[i], 0);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 100) hold_off = 1'b1;
      send_angle($urandom_range(0, 1), random_angle(), (i % 97 < 20) ? 0 : pick_gap());
    end
    valid_i <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 20 * LATENCY + 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Covered %0d items: both functions, angle extremes, quadrant edges.", sent);
    $display("Checked %0d results, %0d still pending.", sb.checked, sb.pending_q.size());
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
